// ===== hdl/serial_command_frame_receiver_top_assert.svh =====
// Assertion macros shared by the frame receiver modules.
// Each macro checks one property on the rising clock edge and is off while reset is active.
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SCFR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("scfr: same-cycle property failed");

// Next-cycle implication.
`define SCFR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scfr: next-cycle property failed");

`endif

// ===== hdl/scfr_pkg.sv =====
`default_nettype none

package scfr_pkg;

  // Default frame layout.
  localparam int FRAME_LEN   = 16;
  localparam int HEADER_POS  = 0;
  localparam int COMMAND_POS = 1;
  localparam int OFFSET_POS  = 1;
  localparam int LENGTH_POS  = 2;
  localparam int VALUE_POS   = 3;

  // Upper bound on byte writes from one set-value frame.
  localparam int MAX_WRITES = 16;
  localparam int WR_CNT_W   = $clog2(MAX_WRITES + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] TIMEOUT_RST = 16'd10;
  localparam logic [7:0]  DOCMD_RST   = 8'd1;
  localparam logic [7:0]  SETVAL_RST  = 8'd2;
  localparam logic [7:0]  BLINK_RST   = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_DOCMD   = 2'd1,
    CFG_SETVAL  = 2'd2,
    CFG_BLINK   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_TIMEOUT = 3'd0,
    EV_ERROR   = 3'd1,
    EV_BLINK   = 3'd2,
    EV_WRITE   = 3'd3,
    EV_IGNORED = 3'd4
  } event_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   take_byte;
    logic   emit_single;
    event_e single_ev;
    logic   write_start;
    logic   emit_write;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic timeout_hit;
    logic frame_end;
    logic sum_ok;
    logic is_docmd;
    logic is_blink;
    logic is_setval;
    logic write_none;
    logic write_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/scfr_dpath.sv =====
`default_nettype none
`include "serial_command_frame_receiver_top_assert.svh"

module scfr_dpath import scfr_pkg::*; #(
  parameter int FrameLen   = FRAME_LEN,
  parameter int HeaderPos  = HEADER_POS,
  parameter int CommandPos = COMMAND_POS,
  parameter int OffsetPos  = OFFSET_POS,
  parameter int LengthPos  = LENGTH_POS,
  parameter int ValuePos   = VALUE_POS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [15:0]           now_time_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_stat_t                   stat_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [2:0]                 event_res_o,
  output logic [7:0]                 write_addr_o,
  output logic [7:0]                 write_data_o,
  output logic                       last_o
);

  localparam int PosW     = $clog2(FrameLen);
  localparam int Room     = (ValuePos < FrameLen) ? (FrameLen - ValuePos) : 0;
  localparam int WriteMax = (Room < MAX_WRITES) ? Room : MAX_WRITES;

  logic [15:0]         timeout_q;
  logic [7:0]          docmd_q;
  logic [7:0]          setval_q;
  logic [7:0]          blink_q;

  logic                in_frame_q;
  logic [PosW-1:0]     pos_q;
  logic [15:0]         last_time_q;
  logic [7:0]          sum_q;
  logic                sum_ok_q;
  logic [7:0]          hdr_q;
  logic [7:0]          cmd_q;
  logic [7:0]          off_q;
  logic [7:0]          len_q;

  logic [7:0]          frame_mem_q [FrameLen];
  logic [7:0]          rd_data_q;
  logic [PosW-1:0]     rd_addr;
  logic [WR_CNT_W-1:0] idx_q;
  logic [WR_CNT_W-1:0] wlen;

  logic                out_valid_q;
  event_e              out_ev_q;
  logic [7:0]          out_addr_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;

  logic [15:0]         gap;
  logic                timeout_hit;
  logic                frame_end;
  logic                store;
  logic                write_last;
  logic                out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      docmd_q   <= DOCMD_RST;
      setval_q  <= SETVAL_RST;
      blink_q   <= BLINK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_DOCMD:   docmd_q   <= cfg_data_i[7:0];
        CFG_SETVAL:  setval_q  <= cfg_data_i[7:0];
        CFG_BLINK:   blink_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Gap check against the previous byte of the frame in progress.
  assign gap         = now_time_i - last_time_q;
  assign timeout_hit = in_frame_q && (gap > timeout_q);
  assign frame_end   = in_frame_q && (pos_q == PosW'(FrameLen - 1));
  assign store       = cmd_i.take_byte && !timeout_hit;

  // Frame tracking, running sum and capture of the fixed header fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      last_time_q <= '0;
      sum_q       <= '0;
      sum_ok_q    <= 1'b0;
      hdr_q       <= '0;
      cmd_q       <= '0;
      off_q       <= '0;
      len_q       <= '0;
    end else if (cmd_i.take_byte) begin
      if (timeout_hit) begin
        in_frame_q <= 1'b0;
        pos_q      <= '0;
      end else begin
        if (!in_frame_q) begin
          in_frame_q  <= 1'b1;
          last_time_q <= now_time_i;
          sum_q       <= rx_byte_i;
          pos_q       <= pos_q + 1'b1;
        end else if (frame_end) begin
          in_frame_q <= 1'b0;
          pos_q      <= '0;
          sum_ok_q   <= (sum_q == rx_byte_i);
        end else begin
          last_time_q <= now_time_i;
          sum_q       <= sum_q + rx_byte_i;
          pos_q       <= pos_q + 1'b1;
        end
        if (int'(pos_q) == HeaderPos) begin
          hdr_q <= rx_byte_i;
        end
        if (int'(pos_q) == CommandPos) begin
          cmd_q <= rx_byte_i;
        end
        if (int'(pos_q) == OffsetPos) begin
          off_q <= rx_byte_i;
        end
        if (int'(pos_q) == LengthPos) begin
          len_q <= rx_byte_i;
        end
      end
    end
  end

  // Frame byte store with a registered read port for the write values.
  assign rd_addr = PosW'(ValuePos + int'(idx_q));

  always_ff @(posedge clk_i) begin
    if (store) begin
      frame_mem_q[pos_q] <= rx_byte_i;
    end
    rd_data_q <= frame_mem_q[rd_addr];
  end

  // Write count: a negative length is zero, then limited to the room left in the frame and to MAX_WRITES.
  always_comb begin
    if (len_q[7]) begin
      wlen = '0;
    end else if (len_q > 8'(WriteMax)) begin
      wlen = WR_CNT_W'(WriteMax);
    end else begin
      wlen = WR_CNT_W'(len_q);
    end
  end

  assign write_last = ((idx_q + WR_CNT_W'(1)) == wlen);

  // Write index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.write_start) begin
      idx_q <= '0;
    end else if (cmd_i.emit_write) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_single || cmd_i.emit_write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      out_ev_q   <= cmd_i.single_ev;
      out_addr_q <= '0;
      out_data_q <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_write) begin
      out_ev_q   <= EV_WRITE;
      out_addr_q <= off_q + 8'(idx_q);
      out_data_q <= rd_data_q;
      out_last_q <= write_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_ev_q;
  assign write_addr_o = out_addr_q;
  assign write_data_o = out_data_q;
  assign last_o       = out_last_q;

  // Status toward the controller.
  always_comb begin
    stat_o.timeout_hit = timeout_hit;
    stat_o.frame_end   = frame_end;
    stat_o.sum_ok      = sum_ok_q;
    stat_o.is_docmd    = (hdr_q == docmd_q);
    stat_o.is_blink    = (cmd_q == blink_q);
    stat_o.is_setval   = (hdr_q == setval_q);
    stat_o.write_none  = (wlen == '0);
    stat_o.write_last  = write_last;
    stat_o.out_free    = out_free;
  end

  `SCFR_ASSERT_IMP(a_idle_pos_zero, clk_i, rst_ni, !in_frame_q, pos_q == '0)
  `SCFR_ASSERT_IMP(a_only_writes_continue, clk_i, rst_ni, out_valid_q && !out_last_q, out_ev_q == EV_WRITE)
  `SCFR_ASSERT_NEXT(a_timeout_abandons, clk_i, rst_ni, cmd_i.take_byte && timeout_hit, !in_frame_q)

endmodule

`default_nettype wire

// ===== hdl/scfr_ctrl.sv =====
`default_nettype none
`include "serial_command_frame_receiver_top_assert.svh"

module scfr_ctrl import scfr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output ctrl_cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_EMIT  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  event_e ev_q, ev_d;
  logic   accept;

  // Bytes are taken only while no frame result is being worked out.
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    ev_d            = ev_q;
    cmd_o           = '0;
    cmd_o.single_ev = ev_q;
    cmd_o.take_byte = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.timeout_hit) begin
            ev_d    = EV_TIMEOUT;
            state_d = ST_EMIT;
          end else if (stat_i.frame_end) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!stat_i.sum_ok) begin
          ev_d    = EV_ERROR;
          state_d = ST_EMIT;
        end else if (stat_i.is_docmd) begin
          ev_d    = stat_i.is_blink ? EV_BLINK : EV_IGNORED;
          state_d = ST_EMIT;
        end else if (stat_i.is_setval) begin
          if (stat_i.write_none) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.write_start = 1'b1;
            state_d           = ST_FETCH;
          end
        end else begin
          ev_d    = EV_IGNORED;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_write = 1'b1;
          state_d          = stat_i.write_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ev_q    <= EV_TIMEOUT;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
    end
  end

  `SCFR_ASSERT_IMP(a_state_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `SCFR_ASSERT_NEXT(a_fetch_to_write, clk_i, rst_ni, state_q == ST_FETCH, state_q == ST_WRITE)
  `SCFR_ASSERT_NEXT(a_final_byte_checks, clk_i, rst_ni, accept && !stat_i.timeout_hit && stat_i.frame_end, state_q == ST_CHECK)

endmodule

`default_nettype wire

// ===== hdl/serial_command_frame_receiver_top.sv =====
// Serial command frame receiver. Received bytes arrive with a 16-bit timestamp and are
// collected into fixed-length frames; a byte that comes later than the configured timeout
// after the previous byte of a frame is dropped, the frame is abandoned and a timeout event
// is given. A full frame is checked against its 8-bit additive sum, a failure giving an
// error event, and is then dispatched on its header byte into a blink or ignored event, or
// a series of configuration byte writes. A byte that does not end a frame is taken without
// holding the input; a byte dropped for a timeout then holds the input while its event is
// loaded. A frame's final byte holds the input for a check state and then the load of a
// single event, or a fetch and a write state per byte write, because each write value
// comes through the registered read port of the frame store; a stalled output lengthens
// each of these waits. The default layout allows at most 13 writes; a longer frame allows
// the full 16 writes. The output register lets the input take a new byte while the last
// result of a frame still waits for its transfer.
`default_nettype none

module serial_command_frame_receiver_top import scfr_pkg::*; #(
  parameter int FrameLen   = FRAME_LEN,
  parameter int HeaderPos  = HEADER_POS,
  parameter int CommandPos = COMMAND_POS,
  parameter int OffsetPos  = OFFSET_POS,
  parameter int LengthPos  = LENGTH_POS,
  parameter int ValuePos   = VALUE_POS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [15:0]           now_time_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 event_res_o,
  output logic [7:0]                 write_addr_o,
  output logic [7:0]                 write_data_o,
  output logic                       last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing of accepts, frame checks and result transfers.
  scfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Frame storage, checks and the output register.
  scfr_dpath #(
    .FrameLen   (FrameLen),
    .HeaderPos  (HeaderPos),
    .CommandPos (CommandPos),
    .OffsetPos  (OffsetPos),
    .LengthPos  (LengthPos),
    .ValuePos   (ValuePos)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .now_time_i   (now_time_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .event_res_o  (event_res_o),
    .write_addr_o (write_addr_o),
    .write_data_o (write_data_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
